// ===== sv/mhm_pkg.sv =====
// Package for the masked histogram matching unit: widths, defaults, the queue item type and the action and state enums.
// Used by the top level, mhm_front and mhm_back; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mhm_pkg;
    localparam int COUNT_BITS_DEF = 20;
    localparam int LEVELS_DEF = 256;
    localparam int CHANNELS_DEF = 3;
    localparam int PIX_BITS = 8;
    localparam int LANES_MAX = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        ACT_ACCUM = 1'b0,
        ACT_APPLY = 1'b1
    } action_t;

    typedef struct packed {
        action_t action;
        logic mask_on;
        logic [LANES_MAX*PIX_BITS-1:0] src;
        logic [LANES_MAX*PIX_BITS-1:0] tgt;
        logic last;
    } item_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_SUM,
        ST_SRCH,
        ST_MUL,
        ST_CMP,
        ST_WRITE,
        ST_CLEAR
    } state_t;
endpackage
`default_nettype wire

// ===== sv/masked_histogram_matching_unit.sv =====
// Masked histogram matching unit: an accumulate request is read, then written back; an apply
// request is looked up, then its result registered. No request is taken before the previous one
// is through, nor an apply while a result is stalled. A last accumulate builds the lookup: prefix
// sums, then search steps through the search, multiply, compare and write states (at most
// 2*LEVELS steps per channel), then a clear. Asynchronous active-low reset clears control
// state and starts a clearing pass over the histograms; maps read as identity until built.
`timescale 1ns / 1ps
`default_nettype none
module masked_histogram_matching_unit
    import mhm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int LEVELS = LEVELS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: src_red, src_green, src_blue, tgt_red, tgt_green, tgt_blue
    input  wire logic [47:0] s_axis_tdata,
    // tuser: action, mask_on
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_red, out_green, out_blue
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    item_t in_item, q_item;
    logic q_valid, q_pop;

    assign in_item.action = action_t'(s_axis_tuser[0]);
    assign in_item.mask_on = s_axis_tuser[1];
    assign in_item.src = s_axis_tdata[23:0];
    assign in_item.tgt = s_axis_tdata[47:24];
    assign in_item.last = s_axis_tlast;

    mhm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    mhm_back #(.COUNT_BITS(COUNT_BITS), .LEVELS(LEVELS), .CHANNELS(CHANNELS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule
`default_nettype wire

// ===== sv/mhm_front.sv =====
// Front part: takes input requests into a short queue for the back part.
// Depends on mhm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mhm_front
    import mhm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       q_valid,
    input  wire logic  q_pop,
    output item_t      q_item
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    item_t mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic push;

    assign in_ready = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = push ? wr_reg + 1'b1 : wr_reg;
        rd_next = q_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/mhm_back.sv =====
// Back part: histogram counting, lookup build and remap of apply requests.
// Depends on mhm_pkg; fed from the queue in mhm_front.
`timescale 1ns / 1ps
`default_nettype none
module mhm_back
    import mhm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int LEVELS = LEVELS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    output logic       q_pop,
    input  wire item_t q_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [LANES_MAX*PIX_BITS-1:0] out_data,
    output logic       out_last
);
    localparam int LANES = (CHANNELS < LANES_MAX) ? CHANNELS : LANES_MAX;
    localparam int LB = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CB = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SB = COUNT_BITS + LB;
    localparam int AB = CB + LB;
    localparam int DEPTH = LANES * LEVELS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [COUNT_BITS-1:0] scnt_mem [LANES][LEVELS];
    logic [COUNT_BITS-1:0] tcnt_mem [LANES][LEVELS];
    logic [SB-1:0] scum_mem [DEPTH];
    logic [SB-1:0] tcum_mem [DEPTH];
    logic [PIX_BITS-1:0] map_mem [LANES][LEVELS];

    state_t state_reg, state_next;
    logic [CB-1:0] ch_reg;
    logic [LB-1:0] i_reg, m_reg;
    logic [SB-1:0] sacc_reg, tacc_reg, ti_reg, sm_reg;
    logic [2*SB-1:0] p1_reg, p2_reg;
    logic sum_ph_reg;
    logic [COUNT_BITS-1:0] sc_rd_reg, tc_rd_reg;
    logic map_ok_reg [LANES];
    logic [LANES-1:0] map_valid_reg;

    logic [PIX_BITS-1:0] odat_reg [LANES_MAX];
    logic ovalid_reg, olast_reg, olast_pend_reg;
    logic apply_ph_reg;
    logic [LANES_MAX-1:0] amask_reg;
    logic [PIX_BITS-1:0] atgt_reg [LANES_MAX];
    logic [PIX_BITS-1:0] mrd_reg [LANES_MAX];

    logic acc_ph_reg, acc_mask_reg, acc_last_reg;
    logic [LB-1:0] acc_ls_reg [LANES];
    logic [LB-1:0] acc_lt_reg [LANES];
    logic [COUNT_BITS-1:0] src_rd_reg [LANES];
    logic [COUNT_BITS-1:0] tgt_rd_reg [LANES];

    // Totals per channel, kept for the search that follows the sums.
    logic [SB-1:0] stot_reg [LANES];
    logic [SB-1:0] ttot_reg [LANES];
    logic [SB-1:0] s_fin, t_fin;

    logic [LB-1:0] lvl_s [LANES_MAX];
    logic [LB-1:0] lvl_t [LANES_MAX];
    logic run_take, acc_take, apply_take;
    logic [AB-1:0] sw_addr;
    logic ge;

    function automatic logic [LB-1:0] clampl(input logic [PIX_BITS-1:0] v);
        logic [LB-1:0] r;
        if (32'(v) >= LEVELS)
        begin
            r = LB'(LEVELS - 1);
        end
        else
        begin
            r = LB'(v);
        end
        return r;
    endfunction

    function automatic logic [AB-1:0] addr(input int c, input logic [LB-1:0] l);
        return AB'(c * LEVELS) + AB'(l);
    endfunction

    always_comb
    begin
        for (int c = 0; c < LANES_MAX; c++)
        begin
            lvl_s[c] = clampl(q_item.src[c*PIX_BITS +: PIX_BITS]);
            lvl_t[c] = clampl(q_item.tgt[c*PIX_BITS +: PIX_BITS]);
        end
    end

    // Accumulate is a read, then a write; apply first registers its lookup.
    assign run_take = (state_reg == ST_RUN) && q_valid && !apply_ph_reg && !acc_ph_reg
        && !(ovalid_reg && !out_ready && q_item.action == ACT_APPLY);
    assign acc_take = run_take && q_item.action == ACT_ACCUM;
    assign apply_take = run_take && q_item.action == ACT_APPLY;
    assign q_pop = run_take;
    assign sw_addr = addr(int'(ch_reg), i_reg);
    assign ge = (p1_reg >= p2_reg);
    assign s_fin = sacc_reg + SB'(sc_rd_reg);
    assign t_fin = tacc_reg + SB'(tc_rd_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (acc_ph_reg && acc_last_reg)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sum_ph_reg && i_reg == LB'(LEVELS - 1) && ch_reg == CB'(LANES - 1))
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: state_next = ST_MUL;
            ST_MUL: state_next = ST_CMP;
            ST_CMP: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (i_reg == LB'(LEVELS - 1) && (ge || m_reg == LB'(LEVELS - 1)
                    || !map_ok_reg[ch_reg]) && ch_reg == CB'(LANES - 1))
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_CLEAR:
            begin
                if (i_reg == LB'(LEVELS - 1) && ch_reg == CB'(LANES - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_SUM:
            begin
                if (!sum_ph_reg)
                begin
                    sc_rd_reg <= scnt_mem[ch_reg][i_reg];
                    tc_rd_reg <= tcnt_mem[ch_reg][i_reg];
                end
                else
                begin
                    scum_mem[sw_addr] <= s_fin;
                    tcum_mem[sw_addr] <= t_fin;
                end
            end
            ST_SRCH:
            begin
                ti_reg <= tcum_mem[sw_addr];
                sm_reg <= scum_mem[addr(int'(ch_reg), m_reg)];
            end
            ST_MUL:
            begin
                p1_reg <= (2*SB)'(sm_reg) * (2*SB)'(tacc_reg);
                p2_reg <= (2*SB)'(ti_reg) * (2*SB)'(sacc_reg);
            end
            ST_WRITE:
            begin
                if (ge || m_reg == LB'(LEVELS - 1) || !map_ok_reg[ch_reg])
                begin
                    map_mem[ch_reg][i_reg] <= map_ok_reg[ch_reg] ? PIX_BITS'(m_reg)
                        : PIX_BITS'(i_reg);
                end
            end
            ST_CLEAR:
            begin
                scnt_mem[ch_reg][i_reg] <= '0;
                tcnt_mem[ch_reg][i_reg] <= '0;
            end
            default:
            begin
            end
        endcase
        if (acc_take)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                src_rd_reg[c] <= scnt_mem[c][lvl_s[c]];
                tgt_rd_reg[c] <= tcnt_mem[c][lvl_t[c]];
                acc_ls_reg[c] <= lvl_s[c];
                acc_lt_reg[c] <= lvl_t[c];
            end
            acc_mask_reg <= q_item.mask_on;
            acc_last_reg <= q_item.last;
        end
        if (apply_take)
        begin
            for (int c = 0; c < LANES_MAX; c++)
            begin
                atgt_reg[c] <= q_item.tgt[c*PIX_BITS +: PIX_BITS];
                amask_reg[c] <= q_item.mask_on && (c < LANES);
                if (c < LANES)
                begin
                    mrd_reg[c] <= map_valid_reg[c]
                        ? map_mem[c][lvl_t[c]] : PIX_BITS'(lvl_t[c]);
                end
                else
                begin
                    mrd_reg[c] <= '0;
                end
            end
            olast_pend_reg <= q_item.last;
        end
        if (acc_ph_reg && acc_mask_reg)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                if (src_rd_reg[c] != CMAX)
                begin
                    scnt_mem[c][acc_ls_reg[c]] <= src_rd_reg[c] + 1'b1;
                end
                if (tgt_rd_reg[c] != CMAX)
                begin
                    tcnt_mem[c][acc_lt_reg[c]] <= tgt_rd_reg[c] + 1'b1;
                end
            end
        end
        if (apply_ph_reg)
        begin
            for (int c = 0; c < LANES_MAX; c++)
            begin
                odat_reg[c] <= amask_reg[c] ? mrd_reg[c] : atgt_reg[c];
            end
            olast_reg <= olast_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ch_reg <= '0;
            i_reg <= '0;
            m_reg <= '0;
            sacc_reg <= '0;
            tacc_reg <= '0;
            sum_ph_reg <= 1'b0;
            acc_ph_reg <= 1'b0;
            apply_ph_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            map_valid_reg <= '0;
            for (int c = 0; c < LANES; c++)
            begin
                map_ok_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            acc_ph_reg <= acc_take;
            apply_ph_reg <= apply_take;
            if (apply_ph_reg)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN:
                begin
                    ch_reg <= '0;
                    i_reg <= '0;
                    m_reg <= '0;
                    sacc_reg <= '0;
                    tacc_reg <= '0;
                    sum_ph_reg <= 1'b0;
                end
                ST_SUM:
                begin
                    sum_ph_reg <= !sum_ph_reg;
                    if (sum_ph_reg)
                    begin
                        if (i_reg == LB'(LEVELS - 1))
                        begin
                            i_reg <= '0;
                            map_ok_reg[ch_reg] <= (s_fin != '0) && (t_fin != '0);
                            map_valid_reg[ch_reg] <= 1'b1;
                            if (ch_reg == CB'(LANES - 1))
                            begin
                                ch_reg <= '0;
                                sacc_reg <= (ch_reg == '0) ? s_fin : stot_reg[0];
                                tacc_reg <= (ch_reg == '0) ? t_fin : ttot_reg[0];
                            end
                            else
                            begin
                                ch_reg <= ch_reg + 1'b1;
                                sacc_reg <= '0;
                                tacc_reg <= '0;
                            end
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            sacc_reg <= s_fin;
                            tacc_reg <= t_fin;
                        end
                    end
                end
                ST_SRCH, ST_MUL, ST_CMP:
                begin
                end
                ST_WRITE:
                begin
                    if (ge || m_reg == LB'(LEVELS - 1) || !map_ok_reg[ch_reg])
                    begin
                        if (i_reg == LB'(LEVELS - 1))
                        begin
                            i_reg <= '0;
                            m_reg <= '0;
                            if (ch_reg != CB'(LANES - 1))
                            begin
                                ch_reg <= ch_reg + 1'b1;
                                sacc_reg <= stot_reg[ch_reg + 1'b1];
                                tacc_reg <= ttot_reg[ch_reg + 1'b1];
                            end
                            else
                            begin
                                ch_reg <= '0;
                            end
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        m_reg <= m_reg + 1'b1;
                    end
                end
                ST_CLEAR:
                begin
                    if (i_reg == LB'(LEVELS - 1))
                    begin
                        i_reg <= '0;
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM && sum_ph_reg && i_reg == LB'(LEVELS - 1))
        begin
            stot_reg[ch_reg] <= s_fin;
            ttot_reg[ch_reg] <= t_fin;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_last = olast_reg;
    always_comb
    begin
        for (int c = 0; c < LANES_MAX; c++)
        begin
            out_data[c*PIX_BITS +: PIX_BITS] = odat_reg[c];
        end
    end
endmodule
`default_nettype wire

// ===== sv/mhm_checker.sv =====
// Port-level checks for the masked histogram matching unit, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module mhm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("stalled last changed");
    a_rst: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid || rst_n)
        else $error("result during reset");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tready))
        else $error("input ready unknown");
endmodule

bind masked_histogram_matching_unit mhm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
